FILE: design/fsrq_pkg.sv
// Shared constants and types for the framed serial receiver queue.
// Depends on nothing; imported by framed_serial_receiver_queue_unit.
package fsrq_pkg;

    // Queue depths; each FIFO keeps one slot empty.
    localparam int FRAME_SLOTS = 16;
    localparam int RAW_SLOTS   = 2048;
    localparam int FRAME_AW    = $clog2(FRAME_SLOTS);
    localparam int RAW_AW      = $clog2(RAW_SLOTS);

    localparam logic [FRAME_AW-1:0] FRAME_LAST = FRAME_AW'(FRAME_SLOTS - 1);
    localparam logic [RAW_AW-1:0]   RAW_LAST   = RAW_AW'(RAW_SLOTS - 1);

    localparam logic [7:0] START_RESET = 8'hC5;
    localparam logic [7:0] CHECK_MASK  = 8'h7F;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] MODE_RX        = 2'd0;
    localparam logic [1:0] MODE_ERR       = 2'd1;
    localparam logic [1:0] MODE_POP_FRAME = 2'd2;
    localparam logic [1:0] MODE_POP_RAW   = 2'd3;

    // Bits of error_kinds.
    localparam int EK_PARITY  = 0;
    localparam int EK_NOISE   = 1;
    localparam int EK_FRAMING = 2;
    localparam int EK_OVERRUN = 3;

    // Event counter slots, in output order.
    localparam int C_RX      = 0;
    localparam int C_FLOST   = 1;
    localparam int C_RLOST   = 2;
    localparam int C_ERR     = 3;
    localparam int C_FRAMING = 4;
    localparam int C_NOISE   = 5;
    localparam int C_OVERRUN = 6;
    localparam int C_PARITY  = 7;
    localparam int N_CNT     = 8;

    // Parser position that holds the checksum byte.
    localparam logic [2:0] POS_CHECK = 3'd4;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40 + 8 + 32 * N_CNT;

    typedef logic [31:0] t_cnt;
    typedef t_cnt t_cnt_set [N_CNT];

    // Frame queue entry: checksum flag, check byte, bytes 0..3.
    typedef struct packed {
        logic        good;
        logic [7:0]  check;
        logic [31:0] body;
    } t_frame_entry;

endpackage

FILE: design/framed_serial_receiver_queue_unit.sv
// Framed serial receiver queue: raw byte FIFO, frame parser, frame FIFO, counters.
// Depends on fsrq_pkg for depths, request codes, counter slots and types.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  s (req)  | in  | i_s_tvalid/o_s_tready | tuser: mode; tdata: rx_byte, error_kinds
//  m (res)  | out | o_m_tvalid/i_m_tready | tuser: read_ok, checksum_good;
//           |     |                     | tdata: frame_bytes, raw_byte_out, counters
//  cfg      | in  | i_cfg_wr_en         | i_cfg_wr_data: start_byte
//
// One word in per cycle and one word out per cycle while the output does not stall;
// each request passes the read stage (synchronous read in the queue memories), then
// the output register. Reset is synchronous and active low; it clears pointers,
// parser and counters, and leaves the queue memories as they are. When the output
// side stalls, the word in the read stage waits for the output register and input
// acceptance stops until the read stage can advance.
module framed_serial_receiver_queue_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [fsrq_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] rx_byte, [11:8] error_kinds
    input  logic [1:0]                     i_s_tuser,  // [1:0] mode
    // master side
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [39:0] frame_bytes, [47:40] raw_byte_out, then 32-bit counters:
    // bytes_received, frames_lost, raw_lost, error_events, framing_errors,
    // noise_errors, overrun_errors, parity_errors
    output logic [fsrq_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                     o_m_tuser,  // [0] read_ok, [1] checksum_good
    // configuration
    input  logic                           i_cfg_wr_en,
    input  logic [7:0]                     i_cfg_wr_data
);
    import fsrq_pkg::*;

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    logic [7:0]          r_start_byte;
    logic [FRAME_AW-1:0] r_fwr, r_frd, n_fwr, n_frd;
    logic [RAW_AW-1:0]   r_rwr, r_rrd, n_rwr, n_rrd;
    logic [2:0]          r_parse_pos, n_parse_pos;
    logic [31:0]         r_partial, n_partial;
    t_cnt_set            r_cnt, n_cnt;

    // Queue memories, synchronous read.
    t_frame_entry        frame_mem [FRAME_SLOTS];
    logic [7:0]          raw_mem   [RAW_SLOTS];
    t_frame_entry        r_frame_rd;
    logic [7:0]          r_raw_rd;

    // Read stage: request waiting for its memory data.
    logic                r_s1_valid;
    logic [1:0]          r_s1_mode;
    logic                r_s1_ok;

    // Output register.
    logic                r_o_valid;
    logic                r_o_ok;
    logic                r_o_good;
    logic [39:0]         r_o_frame;
    logic [7:0]          r_o_raw;
    t_cnt_set            r_o_cnt;

    // ---------------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------------
    logic acc, out_free, s1_move;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [3:0] ek;

    assign out_free   = !r_o_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign acc        = i_s_tvalid && o_s_tready;

    assign mode    = i_s_tuser;
    assign rx_byte = i_s_tdata[7:0];
    assign ek      = i_s_tdata[11:8];

    // ---------------------------------------------------------------------
    // Pointer, parser and counter update for the accepted word
    // ---------------------------------------------------------------------
    logic [FRAME_AW-1:0] fwr_inc, frd_inc;
    logic [RAW_AW-1:0]   rwr_inc, rrd_inc;
    logic                frame_full, frame_empty, raw_full, raw_empty;
    logic                raw_push, frame_push, frame_pop, raw_pop;
    logic [7:0]          xsum;
    t_frame_entry        new_entry;

    assign fwr_inc = (r_fwr == FRAME_LAST) ? '0 : r_fwr + 1'b1;
    assign frd_inc = (r_frd == FRAME_LAST) ? '0 : r_frd + 1'b1;
    assign rwr_inc = (r_rwr == RAW_LAST)   ? '0 : r_rwr + 1'b1;
    assign rrd_inc = (r_rrd == RAW_LAST)   ? '0 : r_rrd + 1'b1;

    assign frame_full  = (fwr_inc == r_frd);
    assign raw_full    = (rwr_inc == r_rrd);
    assign frame_empty = (r_frd == r_fwr);
    assign raw_empty   = (r_rrd == r_rwr);

    assign xsum = (r_partial[7:0] ^ r_partial[15:8] ^ r_partial[23:16] ^ r_partial[31:24])
                  & CHECK_MASK;

    assign new_entry.good  = (rx_byte == xsum);
    assign new_entry.check = rx_byte;
    assign new_entry.body  = r_partial;

    assign raw_push   = acc && (mode == MODE_RX) && !raw_full;
    assign frame_push = acc && (mode == MODE_RX) && (r_parse_pos == POS_CHECK) && !frame_full;
    assign frame_pop  = acc && (mode == MODE_POP_FRAME) && !frame_empty;
    assign raw_pop    = acc && (mode == MODE_POP_RAW) && !raw_empty;

    always_comb begin
        n_fwr       = r_fwr;
        n_frd       = r_frd;
        n_rwr       = r_rwr;
        n_rrd       = r_rrd;
        n_parse_pos = r_parse_pos;
        n_partial   = r_partial;
        n_cnt       = r_cnt;
        if (acc) begin
            case (mode)
                MODE_RX: begin
                    n_cnt[C_RX] = r_cnt[C_RX] + 32'd1;
                    if (raw_full) begin
                        n_cnt[C_RLOST] = r_cnt[C_RLOST] + 32'd1;
                    end else begin
                        n_rwr = rwr_inc;
                    end
                    // Parser: hunt for start, collect bytes 1..3, then check byte.
                    if (r_parse_pos == 3'd0) begin
                        if (rx_byte == r_start_byte) begin
                            n_partial   = {24'd0, rx_byte};
                            n_parse_pos = 3'd1;
                        end
                    end else if (r_parse_pos < POS_CHECK) begin
                        n_partial[8*r_parse_pos[1:0] +: 8] = rx_byte;
                        n_parse_pos = r_parse_pos + 3'd1;
                    end else begin
                        if (frame_full) begin
                            n_cnt[C_FLOST] = r_cnt[C_FLOST] + 32'd1;
                        end else begin
                            n_fwr = fwr_inc;
                        end
                        n_parse_pos = 3'd0;
                        n_partial   = '0;
                    end
                end
                MODE_ERR: begin
                    n_cnt[C_ERR] = r_cnt[C_ERR] + 32'd1;
                    if (ek[EK_FRAMING]) n_cnt[C_FRAMING] = r_cnt[C_FRAMING] + 32'd1;
                    if (ek[EK_NOISE])   n_cnt[C_NOISE]   = r_cnt[C_NOISE] + 32'd1;
                    if (ek[EK_OVERRUN]) n_cnt[C_OVERRUN] = r_cnt[C_OVERRUN] + 32'd1;
                    if (ek[EK_PARITY])  n_cnt[C_PARITY]  = r_cnt[C_PARITY] + 32'd1;
                    n_parse_pos = 3'd0;
                end
                MODE_POP_FRAME: begin
                    if (!frame_empty) n_frd = frd_inc;
                end
                MODE_POP_RAW: begin
                    if (!raw_empty) n_rrd = rrd_inc;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
            r_fwr        <= '0;
            r_frd        <= '0;
            r_rwr        <= '0;
            r_rrd        <= '0;
            r_parse_pos  <= '0;
            r_partial    <= '0;
            for (int i = 0; i < N_CNT; i++) r_cnt[i] <= '0;
        end else begin
            if (i_cfg_wr_en) r_start_byte <= i_cfg_wr_data;
            r_fwr       <= n_fwr;
            r_frd       <= n_frd;
            r_rwr       <= n_rwr;
            r_rrd       <= n_rrd;
            r_parse_pos <= n_parse_pos;
            r_partial   <= n_partial;
            r_cnt       <= n_cnt;
        end
    end

    // ---------------------------------------------------------------------
    // Queue memories. A pop only reads an entry written at an earlier edge,
    // and push and pop never share a word, so no bypass is needed. The read
    // registers load only on a pop, so they hold while the read stage stalls.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (frame_push) frame_mem[r_fwr] <= new_entry;
        if (frame_pop)  r_frame_rd <= frame_mem[r_frd];
    end

    always_ff @(posedge i_clk) begin
        if (raw_push) raw_mem[r_rwr] <= rx_byte;
        if (raw_pop)  r_raw_rd <= raw_mem[r_rrd];
    end

    // ---------------------------------------------------------------------
    // Read stage and output register. While the read stage holds a word no
    // other word has been accepted, so the live counters are exactly that
    // word's counter values; sample them as it moves to the output.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_mode <= mode;
            r_s1_ok   <= frame_pop || raw_pop;
        end
        if (s1_move) begin
            r_o_ok    <= r_s1_ok;
            r_o_good  <= (r_s1_ok && r_s1_mode == MODE_POP_FRAME) ? r_frame_rd.good : 1'b0;
            r_o_frame <= (r_s1_ok && r_s1_mode == MODE_POP_FRAME)
                         ? {r_frame_rd.check, r_frame_rd.body} : 40'd0;
            r_o_raw   <= (r_s1_ok && r_s1_mode == MODE_POP_RAW) ? r_raw_rd : 8'd0;
            r_o_cnt   <= r_cnt;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = {r_o_good, r_o_ok};
    assign o_m_tdata  = {r_o_cnt[C_PARITY], r_o_cnt[C_OVERRUN], r_o_cnt[C_NOISE],
                         r_o_cnt[C_FRAMING], r_o_cnt[C_ERR], r_o_cnt[C_RLOST],
                         r_o_cnt[C_FLOST], r_o_cnt[C_RX], r_o_raw, r_o_frame};

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
`ifndef SYNTHESIS
    a_parse_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_parse_pos <= POS_CHECK)
        else $error("parser position out of range");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_o_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while read stage is stuck");

    a_raw_push_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        raw_push |=> (r_rwr != $past(r_rwr)))
        else $error("raw write pointer did not advance on push");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && mode == MODE_POP_FRAME && frame_empty) |=> !r_s1_ok)
        else $error("frame pop from empty queue reported success");
`endif

endmodule
